/* design/bae_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bae_pkg;

    localparam int CAP_W    = 20;
    localparam int FAC_W    = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // boot modes in which the estimator may start
    localparam logic [3:0] BOOT_NORMAL = 4'd0;
    localparam logic [3:0] BOOT_ALT_A  = 4'd8;
    localparam logic [3:0] BOOT_ALT_B  = 4'd9;

    localparam logic [6:0]       FULL_CHARGE   = 7'd100;
    localparam logic [FAC_W-1:0] FACTOR_NOMINAL = 14'd10000;
    localparam logic [7:0]       PCT_NOMINAL   = 8'd100;
    localparam logic [6:0]       TENS_MAX      = 7'd100;
    localparam logic [6:0]       TENS_STEP     = 7'd10;
    localparam logic [6:0]       TENS_HIGH     = 7'd90;
    localparam logic [6:0]       TENS_MID      = 7'd60;
    localparam logic [4:0]       THOUSANDS_CAP = 5'd9;
    localparam logic [7:0]       LEVEL_NOMINAL = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOOT_MODE      = 3'd0,
        REG_SAVED_CAPACITY = 3'd1,
        REG_SAVED_FACTOR   = 3'd2,
        REG_REMOVED_OVR    = 3'd3,
        REG_FORCED_LEVEL   = 3'd4,
        REG_TEMP_LOW       = 3'd5,
        REG_TEMP_HIGH      = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        logic [6:0]        charge_level;
        logic [CAP_W-1:0]  full_capacity;
        logic [FAC_W-1:0]  wear_factor;
        logic signed [7:0] temperature;
        logic              plugged_out;
    } in_word_t;

    typedef struct packed {
        logic [26:0] capacity_x100;
        logic [7:0]  factor_percent;
        logic [6:0]  factor_tens;
        logic [7:0]  factor_level;
        logic        learned;
        logic        active;
    } out_word_t;

    typedef struct packed {
        logic [3:0]        boot_mode;
        logic [CAP_W-1:0]  saved_capacity;
        logic [FAC_W-1:0]  saved_factor;
        logic signed [1:0] removed_override;
        logic [7:0]        forced_level;
        logic signed [7:0] temp_low;
        logic signed [7:0] temp_high;
    } cfg_t;

    // raw result held in the output register
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [FAC_W-1:0] factor;
        logic [7:0]       forced_level;
        logic             learned;
        logic             active;
    } kept_t;

    // floor(v * 9 / 10) = v - ceil(v / 10); /10 by reciprocal, exact below 2^22
    function automatic logic [CAP_W-1:0] floor_90(input logic [CAP_W-1:0] v);
        logic [CAP_W:0]      t;
        logic [2*CAP_W:0]    p;
        begin
            t = {1'b0, v} + 21'd9;
            p = (2*CAP_W+1)'(t) * (2*CAP_W+1)'(24'hCCCCD);
            floor_90 = v - p[23 +: CAP_W];
        end
    endfunction

    // v / 100 for 14-bit v
    function automatic logic [7:0] div100(input logic [FAC_W-1:0] v);
        logic [27:0] p;
        begin
            p = 28'(v) * 28'd5243;
            div100 = p[19 +: 8];
        end
    endfunction

    // v / 1000 for 14-bit v
    function automatic logic [4:0] div1000(input logic [FAC_W-1:0] v);
        logic [27:0] p;
        begin
            p = 28'(v) * 28'd8389;
            div1000 = p[23 +: 5];
        end
    endfunction

endpackage

`default_nettype wire

/* design/battery_aging_estimator.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake               | word
// ----------+-------------------------+--------------------------------
// in        | in_valid / in_stall     | in_data  (gauge report)
// out       | out_valid / out_stall   | out_data (capacity, factor, level)
// cfg       | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// An accepted word goes into the input register, then one pass of
// state update writes the result register. One word per cycle sustained while out_stall is low.
// The result register lets a new word enter while a result waits; in_stall
// rises only when both registers are full and out_stall is high.
// rst_n clears the estimator state and loads the register defaults.
// cfg_ready is always high.

module battery_aging_estimator #(
    parameter int AVG_DEPTH = 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire bae_pkg::in_word_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output bae_pkg::out_word_t                  out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bae_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bae_pkg::*;

    cfg_t  cfg;
    kept_t res;

    bae_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bae_learn #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_learn (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (res)
    );

    bae_report u_report (
        .res      (res),
        .out_data (out_data)
    );

    // input only backs up when a finished result is waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result register");

    a_learn_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.learned |-> out_data.active)
        else $error("learned without an active estimator");

    a_tens_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.factor_tens >= 7'd10) && (out_data.factor_tens <= 7'd100))
        else $error("factor tens out of range");

    a_level_nominal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.factor_percent == 8'd0 && out_data.factor_level != 8'd0
        |-> out_data.factor_tens == 7'd10 || out_data.factor_level == res.forced_level)
        else $error("level inconsistent with small factor");

endmodule

`default_nettype wire

/* design/bae_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module bae_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bae_pkg::CFG_DATA_W-1:0] cfg_data,
    output bae_pkg::cfg_t                       cfg
);
    import bae_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (cfg_index)
                REG_BOOT_MODE:      cfg_next.boot_mode        = cfg_data[3:0];
                REG_SAVED_CAPACITY: cfg_next.saved_capacity   = cfg_data[CAP_W-1:0];
                REG_SAVED_FACTOR:   cfg_next.saved_factor     = cfg_data[FAC_W-1:0];
                REG_REMOVED_OVR:    cfg_next.removed_override = cfg_data[1:0];
                REG_FORCED_LEVEL:   cfg_next.forced_level     = cfg_data[7:0];
                REG_TEMP_LOW:       cfg_next.temp_low         = cfg_data[7:0];
                REG_TEMP_HIGH:      cfg_next.temp_high        = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boot_mode        <= BOOT_NORMAL;
            cfg_reg.saved_capacity   <= '0;
            cfg_reg.saved_factor     <= '0;
            cfg_reg.removed_override <= 2'sb11;
            cfg_reg.forced_level     <= '0;
            cfg_reg.temp_low         <= 8'sd15;
            cfg_reg.temp_high        <= 8'sd45;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/bae_learn.sv */
`timescale 1ns / 1ps
`default_nettype none

module bae_learn #(
    parameter int AVG_DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bae_pkg::in_word_t in_data,
    input  wire bae_pkg::cfg_t     cfg,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output bae_pkg::kept_t         res
);
    import bae_pkg::*;

    localparam int CNT_W     = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W     = CAP_W + $clog2(AVG_DEPTH);
    localparam int SUMF_W    = FAC_W + $clog2(AVG_DEPTH);
    // sum / AVG_DEPTH by reciprocal; rounding error stays below one step
    localparam int RECIP_SH  = SUM_W + 3;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int RECIP     = ((1 << RECIP_SH) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int PC_W      = SUM_W + RECIP_W;
    localparam int PF_W      = SUMF_W + RECIP_W;

    // input stage
    in_word_t s1_reg;
    logic     s1_valid_reg, s1_valid_next;

    // estimator state
    logic                ready_reg, ready_next;
    logic [CAP_W-1:0]    kept_cap_reg, kept_cap_next;
    logic [FAC_W-1:0]    kept_fac_reg, kept_fac_next;
    logic [CAP_W-1:0]    last_seen_reg, last_seen_next;
    logic [1:0]          change_cnt_reg, change_cnt_next;
    logic [CNT_W-1:0]    slot_reg, slot_next;
    logic [SUM_W-1:0]    sum_cap_reg, sum_cap_next;
    logic [SUMF_W-1:0]   sum_fac_reg, sum_fac_next;
    logic                mean_valid_reg, mean_valid_next;
    logic [CAP_W-1:0]    mean_cap_reg, mean_cap_next;
    logic [FAC_W-1:0]    mean_fac_reg, mean_fac_next;

    // result stage
    kept_t res_reg, res_next;
    logic  res_valid_reg, res_valid_next;

    logic advance, accept;
    logic enabled, do_init, removed, cur_ready;
    logic [CAP_W-1:0] cur_cap;
    logic [FAC_W-1:0] cur_fac;
    logic in_window, candidate, first_change, take, fill_done, update;
    logic [SUM_W-1:0]  sum_cap_add;
    logic [SUMF_W-1:0] sum_fac_add;
    logic [PC_W-1:0]   prod_cap;
    logic [PF_W-1:0]   prod_fac;
    logic [CAP_W:0]    run_cap_sum;
    logic [FAC_W:0]    run_fac_sum;
    logic [CAP_W-1:0]  new_mean_cap, floor_cap, upd_cap;
    logic [FAC_W-1:0]  new_mean_fac, floor_fac, upd_fac, fac_base;
    logic [CAP_W-1:0]  floor_fac_w;

    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        enabled = (cfg.boot_mode == BOOT_NORMAL) || (cfg.boot_mode == BOOT_ALT_A)
               || (cfg.boot_mode == BOOT_ALT_B);
        do_init = !ready_reg && enabled;
        // negative override defers to the gauge's plug-out flag
        removed = cfg.removed_override[1] ? s1_reg.plugged_out : cfg.removed_override[0];
        cur_ready = ready_reg || do_init;
        cur_cap = do_init ? (removed ? '0 : cfg.saved_capacity) : kept_cap_reg;
        cur_fac = do_init ? (removed ? '0 : cfg.saved_factor) : kept_fac_reg;

        in_window = (s1_reg.temperature >= cfg.temp_low)
                 && (s1_reg.temperature < cfg.temp_high);
        candidate = cur_ready && (s1_reg.charge_level >= FULL_CHARGE) && in_window
                 && (s1_reg.full_capacity != last_seen_reg);
        first_change = (change_cnt_reg == 2'd0);
        take = candidate && !first_change;
        fill_done = (slot_reg == CNT_W'(AVG_DEPTH - 1));
        update = take && (mean_valid_reg || fill_done);

        sum_cap_add = sum_cap_reg + SUM_W'(s1_reg.full_capacity);
        sum_fac_add = sum_fac_reg + SUMF_W'(s1_reg.wear_factor);
        prod_cap = PC_W'(sum_cap_add) * PC_W'(RECIP);
        prod_fac = PF_W'(sum_fac_add) * PF_W'(RECIP);
        run_cap_sum = {1'b0, mean_cap_reg} + {1'b0, s1_reg.full_capacity};
        run_fac_sum = {1'b0, mean_fac_reg} + {1'b0, s1_reg.wear_factor};

        new_mean_cap = mean_valid_reg ? run_cap_sum[CAP_W:1] : prod_cap[RECIP_SH +: CAP_W];
        new_mean_fac = mean_valid_reg ? run_fac_sum[FAC_W:1] : prod_fac[RECIP_SH +: FAC_W];

        // never fall below 90% of the prior value; zero factor means nominal
        fac_base    = (cur_fac == '0) ? FACTOR_NOMINAL : cur_fac;
        floor_cap   = floor_90(cur_cap);
        floor_fac_w = floor_90(CAP_W'(fac_base));
        floor_fac   = floor_fac_w[FAC_W-1:0];
        upd_cap = (new_mean_cap > floor_cap) ? new_mean_cap : floor_cap;
        upd_fac = (new_mean_fac > floor_fac) ? new_mean_fac : floor_fac;
    end

    always_comb
    begin
        s1_valid_next   = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        res_valid_next  = advance ? 1'b1 : (res_valid_reg && !res_stall ? 1'b0 : res_valid_reg);

        ready_next      = ready_reg;
        kept_cap_next   = kept_cap_reg;
        kept_fac_next   = kept_fac_reg;
        last_seen_next  = last_seen_reg;
        change_cnt_next = change_cnt_reg;
        slot_next       = slot_reg;
        sum_cap_next    = sum_cap_reg;
        sum_fac_next    = sum_fac_reg;
        mean_valid_next = mean_valid_reg;
        mean_cap_next   = mean_cap_reg;
        mean_fac_next   = mean_fac_reg;
        res_next        = res_reg;

        if (advance)
        begin
            ready_next    = cur_ready;
            kept_cap_next = update ? upd_cap : cur_cap;
            kept_fac_next = update ? upd_fac : cur_fac;
            if (candidate)
            begin
                last_seen_next  = s1_reg.full_capacity;
                change_cnt_next = first_change ? 2'd1 : 2'd2;
            end
            if (take)
            begin
                if (mean_valid_reg)
                begin
                    mean_cap_next = new_mean_cap;
                    mean_fac_next = new_mean_fac;
                end
                else
                begin
                    sum_cap_next = sum_cap_add;
                    sum_fac_next = sum_fac_add;
                    slot_next    = slot_reg + CNT_W'(1);
                    if (fill_done)
                    begin
                        mean_cap_next   = new_mean_cap;
                        mean_fac_next   = new_mean_fac;
                        mean_valid_next = 1'b1;
                    end
                end
            end
            res_next.capacity     = kept_cap_next;
            res_next.factor       = kept_fac_next;
            res_next.forced_level = cfg.forced_level;
            res_next.learned      = update;
            res_next.active       = cur_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            ready_reg      <= 1'b0;
            kept_cap_reg   <= '0;
            kept_fac_reg   <= '0;
            last_seen_reg  <= '0;
            change_cnt_reg <= '0;
            slot_reg       <= '0;
            sum_cap_reg    <= '0;
            sum_fac_reg    <= '0;
            mean_valid_reg <= 1'b0;
            mean_cap_reg   <= '0;
            mean_fac_reg   <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            res_valid_reg  <= res_valid_next;
            ready_reg      <= ready_next;
            kept_cap_reg   <= kept_cap_next;
            kept_fac_reg   <= kept_fac_next;
            last_seen_reg  <= last_seen_next;
            change_cnt_reg <= change_cnt_next;
            slot_reg       <= slot_next;
            sum_cap_reg    <= sum_cap_next;
            sum_fac_reg    <= sum_fac_next;
            mean_valid_reg <= mean_valid_next;
            mean_cap_reg   <= mean_cap_next;
            mean_fac_reg   <= mean_fac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= in_data;
        end
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

/* design/bae_report.sv */
`timescale 1ns / 1ps
`default_nettype none

module bae_report (
    input  wire bae_pkg::kept_t res,
    output bae_pkg::out_word_t  out_data
);
    import bae_pkg::*;

    logic [26:0] cap_w;
    logic [4:0]  thousands;
    logic [6:0]  tens;
    logic [7:0]  level;

    always_comb
    begin
        cap_w = 27'(res.capacity);
        out_data.capacity_x100 = (cap_w << 6) + (cap_w << 5) + (cap_w << 2);

        thousands = div1000(res.factor);
        tens = (thousands >= THOUSANDS_CAP) ? TENS_MAX
             : 7'((7'(thousands) + 7'd1) * TENS_STEP);
        if (tens >= TENS_HIGH)
        begin
            level = 8'(tens) + 8'd1;
        end
        else if (tens >= TENS_MID)
        begin
            level = 8'(tens) + 8'd2;
        end
        else
        begin
            level = 8'(tens) + 8'd3;
        end

        if (res.factor == '0)
        begin
            out_data.factor_percent = PCT_NOMINAL;
            out_data.factor_tens    = TENS_MAX;
            level                   = LEVEL_NOMINAL;
        end
        else
        begin
            out_data.factor_percent = div100(res.factor);
            out_data.factor_tens    = tens;
        end

        out_data.factor_level = (res.forced_level != '0) ? res.forced_level : level;
        out_data.learned      = res.learned;
        out_data.active       = res.active;
    end

endmodule

`default_nettype wire
